@@ hdl/cgm_pkg.sv @@
// Shared types and constants for the curve gradient moments block.
package cgm_pkg;

   localparam int MAX_POINTS_DEF = 4096;
   localparam int GRAD_WIDTH_DEF = 16;

   localparam int MEAN_W        = 16;
   localparam int MOMENT_DIAG_W = 31;
   localparam int MOMENT_XY_W   = 32;
   localparam int COUNT_OUT_W   = 13;
   localparam int WIDE_W        = 64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_OUT_WAIT
   } state_type;

   typedef enum logic [2:0] {
      SEL_GX,
      SEL_GY,
      SEL_GXX,
      SEL_GXY,
      SEL_GYY
   } sel_type;

   typedef struct packed {
      logic    accept;
      logic    mul;
      logic    add;
      logic    div_start;
      logic    div_store;
      logic    out_load;
      sel_type sel;
   } cmd_type;

   typedef struct packed {
      logic last_item;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

@@ hdl/cgm_divider.sv @@
// Shared restoring divider: signed numerator by unsigned count, one bit per cycle.
module cgm_divider #(
   parameter int NUM_W = 45,
   parameter int DEN_W = 13
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] numer,
   input  logic        [DEN_W-1:0] denom,
   output logic                    done,
   output logic signed [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic                    busy_ff, busy_in;
   logic                    fix_ff, fix_in;
   logic                    done_ff, done_in;
   logic                    neg_ff, neg_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [NUM_W-1:0]        quo_ff, quo_in;
   logic [DEN_W-1:0]        rem_ff, rem_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic signed [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W:0]          rem_sh;
   logic [DEN_W:0]          diff;

   always_comb begin
      busy_in = busy_ff;
      fix_in  = 1'b0;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
      diff    = rem_sh - {1'b0, den_ff};
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         neg_in  = numer[NUM_W-1];
         quo_in  = numer[NUM_W-1] ? (~numer + NUM_W'(1)) : numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CNT_W'(NUM_W);
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract where it fits
         if (!diff[DEN_W]) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end
      if (fix_ff) begin
         // restore the sign: truncation toward zero
         quot_in = neg_ff ? (~quo_ff + NUM_W'(1)) : quo_ff;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

@@ hdl/cgm_datapath.sv @@
// Datapath: input and product registers, accumulators, divider and result beat register.
module cgm_datapath #(
   parameter int MAX_POINTS = cgm_pkg::MAX_POINTS_DEF,
   parameter int GRAD_WIDTH = cgm_pkg::GRAD_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cgm_pkg::cmd_type                       cmd,
   output cgm_pkg::status_type                    status,
   input  logic signed [GRAD_WIDTH-1:0]           req_grad_x,
   input  logic signed [GRAD_WIDTH-1:0]           req_grad_y,
   input  logic                                   req_last_point,
   input  logic                                   rsp_stall,
   output logic                                   rsp_valid,
   output logic signed [cgm_pkg::MEAN_W-1:0]      rsp_mean_x,
   output logic signed [cgm_pkg::MEAN_W-1:0]      rsp_mean_y,
   output logic [cgm_pkg::MOMENT_DIAG_W-1:0]      rsp_moment_xx,
   output logic signed [cgm_pkg::MOMENT_XY_W-1:0] rsp_moment_xy,
   output logic [cgm_pkg::MOMENT_DIAG_W-1:0]      rsp_moment_yy,
   output logic [cgm_pkg::COUNT_OUT_W-1:0]        rsp_point_count,
   output logic                                   rsp_overflow
);

   localparam int CW    = $clog2(MAX_POINTS + 1);
   localparam int LS    = GRAD_WIDTH + CW;
   localparam int PW    = 2 * GRAD_WIDTH;
   localparam int PS_RAW = PW + CW;
   localparam int PS    = (PS_RAW > cgm_pkg::WIDE_W) ? cgm_pkg::WIDE_W : PS_RAW;
   localparam int MW    = cgm_pkg::MEAN_W;
   localparam int DW    = cgm_pkg::MOMENT_DIAG_W;
   localparam int XW    = cgm_pkg::MOMENT_XY_W;
   localparam int OW    = cgm_pkg::COUNT_OUT_W;

   // input stage
   logic signed [GRAD_WIDTH-1:0] in_gx_ff, in_gy_ff;
   logic                         in_last_ff, in_acc_ff;
   // product stage
   logic signed [GRAD_WIDTH-1:0] prod_gx_ff, prod_gy_ff;
   logic signed [PW-1:0]         prod_xx_ff, prod_xy_ff, prod_yy_ff;
   logic                         prod_last_ff, prod_acc_ff;
   // accumulators
   logic signed [LS-1:0]         sum_gx_ff, sum_gy_ff;
   logic signed [PS-1:0]         sum_gxx_ff, sum_gxy_ff, sum_gyy_ff;
   logic [CW-1:0]                count_ff;
   logic                         overflow_ff;
   // quotient hold registers
   logic signed [MW-1:0]         hold_mx_ff, hold_my_ff;
   logic [DW-1:0]                hold_xx_ff, hold_yy_ff;
   logic signed [XW-1:0]         hold_xy_ff;
   // result beat register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [MW-1:0]         out_mx_ff, out_my_ff;
   logic [DW-1:0]                out_xx_ff, out_yy_ff;
   logic signed [XW-1:0]         out_xy_ff;
   logic [OW-1:0]                out_cnt_ff;
   logic                         out_ovf_ff;

   logic signed [PS-1:0]         div_numer;
   logic signed [PS-1:0]         div_quot;
   logic                         div_done;
   logic signed [cgm_pkg::WIDE_W-1:0] quot_wide;
   logic [cgm_pkg::WIDE_W-1:0]   count_wide;
   logic                         room;

   assign room       = count_ff < CW'(MAX_POINTS);
   assign quot_wide  = cgm_pkg::WIDE_W'(div_quot);
   assign count_wide = cgm_pkg::WIDE_W'(count_ff);

   always_comb begin
      case (cmd.sel)
         cgm_pkg::SEL_GX:  div_numer = PS'(sum_gx_ff);
         cgm_pkg::SEL_GY:  div_numer = PS'(sum_gy_ff);
         cgm_pkg::SEL_GXX: div_numer = sum_gxx_ff;
         cgm_pkg::SEL_GXY: div_numer = sum_gxy_ff;
         cgm_pkg::SEL_GYY: div_numer = sum_gyy_ff;
         default:          div_numer = '0;
      endcase
   end

   cgm_divider #(
      .NUM_W (PS),
      .DEN_W (CW)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (div_numer),
      .denom (count_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // take a point, counting it only while below the limit
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         in_gx_ff   <= req_grad_x;
         in_gy_ff   <= req_grad_y;
         in_last_ff <= req_last_point;
         in_acc_ff  <= room;
      end
      if (cmd.mul) begin
         prod_gx_ff   <= in_gx_ff;
         prod_gy_ff   <= in_gy_ff;
         prod_xx_ff   <= PW'(in_gx_ff) * PW'(in_gx_ff);
         prod_xy_ff   <= PW'(in_gx_ff) * PW'(in_gy_ff);
         prod_yy_ff   <= PW'(in_gy_ff) * PW'(in_gy_ff);
         prod_last_ff <= in_last_ff;
         prod_acc_ff  <= in_acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.out_load) begin
         sum_gx_ff   <= '0;
         sum_gy_ff   <= '0;
         sum_gxx_ff  <= '0;
         sum_gxy_ff  <= '0;
         sum_gyy_ff  <= '0;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            if (room) begin
               count_ff <= count_ff + CW'(1);
            end else begin
               overflow_ff <= 1'b1;
            end
         end
         if (cmd.add && prod_acc_ff) begin
            sum_gx_ff  <= sum_gx_ff + LS'(prod_gx_ff);
            sum_gy_ff  <= sum_gy_ff + LS'(prod_gy_ff);
            sum_gxx_ff <= sum_gxx_ff + PS'(prod_xx_ff);
            sum_gxy_ff <= sum_gxy_ff + PS'(prod_xy_ff);
            sum_gyy_ff <= sum_gyy_ff + PS'(prod_yy_ff);
         end
      end
   end

   // hold each quotient, masked to its field
   always_ff @(posedge clock) begin
      if (cmd.div_store) begin
         case (cmd.sel)
            cgm_pkg::SEL_GX:  hold_mx_ff <= quot_wide[MW-1:0];
            cgm_pkg::SEL_GY:  hold_my_ff <= quot_wide[MW-1:0];
            cgm_pkg::SEL_GXX: hold_xx_ff <= quot_wide[DW-1:0];
            cgm_pkg::SEL_GXY: hold_xy_ff <= quot_wide[XW-1:0];
            cgm_pkg::SEL_GYY: hold_yy_ff <= quot_wide[DW-1:0];
            default:          hold_mx_ff <= hold_mx_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.out_load) begin
         out_mx_ff  <= hold_mx_ff;
         out_my_ff  <= hold_my_ff;
         out_xx_ff  <= hold_xx_ff;
         out_xy_ff  <= hold_xy_ff;
         out_yy_ff  <= hold_yy_ff;
         out_cnt_ff <= count_wide[OW-1:0];
         out_ovf_ff <= overflow_ff;
      end
   end

   assign status.last_item = prod_last_ff;
   assign status.div_done  = div_done;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mean_x      = out_mx_ff;
   assign rsp_mean_y      = out_my_ff;
   assign rsp_moment_xx   = out_xx_ff;
   assign rsp_moment_xy   = out_xy_ff;
   assign rsp_moment_yy   = out_yy_ff;
   assign rsp_point_count = out_cnt_ff;
   assign rsp_overflow    = out_ovf_ff;

endmodule

@@ hdl/cgm_ctrl.sv @@
// Controller: sequences accept, multiply, accumulate, the five divisions and the result beat.
module cgm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output cgm_pkg::cmd_type    cmd,
   input  cgm_pkg::status_type status
);

   cgm_pkg::state_type state_ff, state_in;
   cgm_pkg::sel_type   sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cgm_pkg::ST_IDLE;
         sel_ff   <= cgm_pkg::SEL_GX;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      req_stall     = 1'b1;
      cmd           = '0;
      cmd.sel       = sel_ff;
      unique case (state_ff)
         cgm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = cgm_pkg::ST_MUL;
            end
         end
         cgm_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = cgm_pkg::ST_ADD;
         end
         cgm_pkg::ST_ADD: begin
            cmd.add = 1'b1;
            if (status.last_item) begin
               sel_in   = cgm_pkg::SEL_GX;
               state_in = cgm_pkg::ST_DIV_START;
            end else begin
               req_stall = 1'b0;
               if (req_valid) begin
                  cmd.accept = 1'b1;
                  state_in   = cgm_pkg::ST_MUL;
               end else begin
                  state_in = cgm_pkg::ST_IDLE;
               end
            end
         end
         cgm_pkg::ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = cgm_pkg::ST_DIV_RUN;
         end
         cgm_pkg::ST_DIV_RUN: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               state_in      = cgm_pkg::ST_DIV_START;
               unique case (sel_ff)
                  cgm_pkg::SEL_GX:  sel_in = cgm_pkg::SEL_GY;
                  cgm_pkg::SEL_GY:  sel_in = cgm_pkg::SEL_GXX;
                  cgm_pkg::SEL_GXX: sel_in = cgm_pkg::SEL_GXY;
                  cgm_pkg::SEL_GXY: sel_in = cgm_pkg::SEL_GYY;
                  cgm_pkg::SEL_GYY: state_in = cgm_pkg::ST_OUT_WAIT;
                  default:          state_in = cgm_pkg::ST_OUT_WAIT;
               endcase
            end
         end
         cgm_pkg::ST_OUT_WAIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = cgm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cgm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/curve_gradient_moments.sv @@
// Top level: structure-tensor moments of a curve's gradients, one result beat per curve.
// Mid-curve points overlap: the next point is accepted in the accumulate cycle of the one before.
// From the last point to its result beat: accumulate, then for each of the five sums a divider
//    start and run on the one shared bit-serial divider over PS = min(64, 2*GRAD_WIDTH +
//    clog2(MAX_POINTS+1)) numerator bits, then a wait until the result beat register is free.
// Reset (synchronous): clears all sums, the count, the overflow flag and the result beat.
module curve_gradient_moments #(
   parameter int MAX_POINTS = cgm_pkg::MAX_POINTS_DEF,
   parameter int GRAD_WIDTH = cgm_pkg::GRAD_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // point beats
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [GRAD_WIDTH-1:0]           req_grad_x,
   input  logic signed [GRAD_WIDTH-1:0]           req_grad_y,
   input  logic                                   req_last_point,
   // result beats
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [cgm_pkg::MEAN_W-1:0]      rsp_mean_x,
   output logic signed [cgm_pkg::MEAN_W-1:0]      rsp_mean_y,
   output logic [cgm_pkg::MOMENT_DIAG_W-1:0]      rsp_moment_xx,
   output logic signed [cgm_pkg::MOMENT_XY_W-1:0] rsp_moment_xy,
   output logic [cgm_pkg::MOMENT_DIAG_W-1:0]      rsp_moment_yy,
   output logic [cgm_pkg::COUNT_OUT_W-1:0]        rsp_point_count,
   output logic                                   rsp_overflow
);

   // Commands flow from the controller to the datapath; status flows back.
   cgm_pkg::cmd_type    cmd;
   cgm_pkg::status_type status;

   // The controller owns the point handshake: it drops stall only in idle and in the
   // accumulate cycle of a point that does not end its curve.
   cgm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the result beat in its own register, so points of the next
   // curve are taken while a finished result still waits downstream; only a second
   // finished result waits for that register to free.
   cgm_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .GRAD_WIDTH (GRAD_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_grad_x      (req_grad_x),
      .req_grad_y      (req_grad_y),
      .req_last_point  (req_last_point),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_mean_x      (rsp_mean_x),
      .rsp_mean_y      (rsp_mean_y),
      .rsp_moment_xx   (rsp_moment_xx),
      .rsp_moment_xy   (rsp_moment_xy),
      .rsp_moment_yy   (rsp_moment_yy),
      .rsp_point_count (rsp_point_count),
      .rsp_overflow    (rsp_overflow)
   );

endmodule
